@@ design/bop_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_pkg: shared types and constants of the binomial option pricer
// Lattice depth, fixed-point widths, register indexes and the structs that
// travel between the controller, the value chain and the rollback unit.
// ----------------------------------------------------------------------------
package bop_pkg;

  localparam int MaxSteps = 64;
  localparam int LatDepth = MaxSteps + 1;
  localparam int IdxW     = $clog2(LatDepth);
  localparam int OccW     = $clog2(LatDepth + 1);
  localparam int NW       = $clog2(MaxSteps + 1);

  localparam int PriceW = 32;
  localparam int FactW  = 32;
  localparam int ProbW  = 31;
  localparam int StepW  = 7;
  localparam int FracW  = 30;

  localparam int DataW    = 32;
  localparam int AddrW    = 5;
  localparam int RegIdxW  = AddrW - 2;

  localparam logic [ProbW-1:0] OneQ30 = ProbW'(64'd1 << FracW);

  localparam logic [RegIdxW-1:0] RegStepCount = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegUpFactor  = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] RegDownFactor = RegIdxW'(2);
  localparam logic [RegIdxW-1:0] RegUpProb    = RegIdxW'(3);
  localparam logic [RegIdxW-1:0] RegDiscount  = RegIdxW'(4);

  typedef struct packed {
    logic [PriceW-1:0] call;
    logic [PriceW-1:0] put;
  } pair_t;

  typedef struct packed {
    logic            pop;
    logic            push;
    logic [IdxW-1:0] push_idx;
  } chain_ctl_t;

  typedef struct packed {
    logic  valid;
    pair_t vu;
    pair_t vd;
  } rb_req_t;

endpackage

@@ design/bop_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_req_if: request channel of the option pricer
// Carries one pricing request item: spot and strike, both Q16.16.
// ----------------------------------------------------------------------------
interface bop_req_if;
  logic                       valid;
  logic                       ready;
  logic [bop_pkg::PriceW-1:0] spot_price;
  logic [bop_pkg::PriceW-1:0] strike_price;

  modport source (output valid, spot_price, strike_price, input ready);
  modport sink (input valid, spot_price, strike_price, output ready);
endinterface

@@ design/bop_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_rsp_if: result channel of the option pricer
// Carries one result item: call and put value at the root and the leaf
// saturation flag.
// ----------------------------------------------------------------------------
interface bop_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bop_pkg::PriceW-1:0] call_price;
  logic [bop_pkg::PriceW-1:0] put_price;
  logic                       saturated;

  modport source (output valid, call_price, put_price, saturated, input ready);
  modport sink (input valid, call_price, put_price, saturated, output ready);
endinterface

@@ design/bop_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_cell: one node of the lattice value chain
// Holds one call/put pair. It loads a new pair, takes its upper neighbor's
// pair when the chain shifts toward the head, or holds.
// ----------------------------------------------------------------------------
module bop_cell (
  input  logic           clk_i,
  input  logic           shift_i,
  input  logic           load_i,
  input  bop_pkg::pair_t load_val_i,
  input  bop_pkg::pair_t next_val_i,
  output bop_pkg::pair_t val_o
);

  bop_pkg::pair_t val_q;
  bop_pkg::pair_t val_d;

  always_comb begin
    val_d = val_q;
    if (load_i) begin
      val_d = load_val_i;
    end else if (shift_i) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

@@ design/bop_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_chain: shift-line queue of lattice values
// A row of cells that behaves as a first-in first-out queue. The oldest
// value sits in cell 0; a pop moves every cell one place toward the head
// and a push writes the first free cell after the move.
// ----------------------------------------------------------------------------
module bop_chain (
  input  logic                clk_i,
  input  bop_pkg::chain_ctl_t ctl_i,
  input  bop_pkg::pair_t      push_val_i,
  output bop_pkg::pair_t      head_o
);

  bop_pkg::pair_t cell_val [bop_pkg::LatDepth];

  for (genvar k = 0; k < bop_pkg::LatDepth; k++) begin : g_cell
    bop_pkg::pair_t above;
    logic           load;

    if (k == bop_pkg::LatDepth - 1) begin : g_top
      assign above = cell_val[k];
    end else begin : g_mid
      assign above = cell_val[k+1];
    end

    assign load = ctl_i.push && (ctl_i.push_idx == bop_pkg::IdxW'(k));

    bop_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (ctl_i.pop),
      .load_i     (load),
      .load_val_i (push_val_i),
      .next_val_i (above),
      .val_o      (cell_val[k])
    );
  end

  assign head_o = cell_val[0];

endmodule

@@ design/bop_leaf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_leaf: leaf price and payoff sequencer
// Walks the leaves from the all-up leaf down to the all-down leaf. A prefix
// register holds the spot after the down moves of the current leaf; the
// leaf price then takes its up moves one multiply per cycle. Each product is
// rounded half up and clamped to 32 bits.
// ----------------------------------------------------------------------------
module bop_leaf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bop_pkg::PriceW-1:0] spot_i,
  input  logic [bop_pkg::PriceW-1:0] strike_i,
  input  logic [bop_pkg::NW-1:0]     steps_i,
  input  logic [bop_pkg::FactW-1:0]  up_i,
  input  logic [bop_pkg::FactW-1:0]  down_i,
  output logic                       leaf_valid_o,
  output logic                       leaf_last_o,
  output bop_pkg::pair_t             leaf_o,
  output logic                       sat_o
);

  localparam int ProdW = bop_pkg::PriceW + bop_pkg::FactW;
  localparam int MovW  = ProdW - bop_pkg::FracW;
  localparam logic [ProdW-1:0] HalfLsb = ProdW'(64'd1 << (bop_pkg::FracW - 1));

  logic                       busy_q, busy_d;
  logic [bop_pkg::NW-1:0]     j_q, j_d;
  logic [bop_pkg::NW-1:0]     k_q, k_d;
  logic [bop_pkg::PriceW-1:0] x_q, x_d;
  logic [bop_pkg::PriceW-1:0] pref_q, pref_d;
  logic [bop_pkg::PriceW-1:0] strike_q, strike_d;
  logic                       sat_q, sat_d;

  logic [bop_pkg::PriceW-1:0] mul_a;
  logic [bop_pkg::FactW-1:0]  mul_b;
  logic [ProdW-1:0]           prod;
  logic [MovW-1:0]            moved;
  logic                       mv_over;
  logic [bop_pkg::PriceW-1:0] mv_price;

  // Up moves on the leaf price while any remain, else one more down move
  // on the prefix for the next leaf.
  assign mul_a    = (k_q != '0) ? x_q : pref_q;
  assign mul_b    = (k_q != '0) ? up_i : down_i;
  assign prod     = ProdW'(mul_a) * ProdW'(mul_b) + HalfLsb;
  assign moved    = prod[ProdW-1:bop_pkg::FracW];
  assign mv_over  = |moved[MovW-1:bop_pkg::PriceW];
  assign mv_price = mv_over ? '1 : moved[bop_pkg::PriceW-1:0];

  always_comb begin
    busy_d       = busy_q;
    j_d          = j_q;
    k_d          = k_q;
    x_d          = x_q;
    pref_d       = pref_q;
    strike_d     = strike_q;
    sat_d        = sat_q;
    leaf_valid_o = 1'b0;
    leaf_last_o  = 1'b0;
    if (start_i) begin
      busy_d   = 1'b1;
      j_d      = steps_i;
      k_d      = steps_i;
      x_d      = spot_i;
      pref_d   = spot_i;
      strike_d = strike_i;
      sat_d    = 1'b0;
    end else if (busy_q) begin
      if (k_q != '0) begin
        x_d   = mv_price;
        k_d   = k_q - bop_pkg::NW'(1);
        sat_d = sat_q | mv_over;
      end else begin
        leaf_valid_o = 1'b1;
        if (j_q == '0) begin
          busy_d      = 1'b0;
          leaf_last_o = 1'b1;
        end else begin
          pref_d = mv_price;
          x_d    = mv_price;
          j_d    = j_q - bop_pkg::NW'(1);
          k_d    = j_q - bop_pkg::NW'(1);
          sat_d  = sat_q | mv_over;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      j_q    <= '0;
      k_q    <= '0;
      sat_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      j_q    <= j_d;
      k_q    <= k_d;
      sat_q  <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    pref_q   <= pref_d;
    strike_q <= strike_d;
  end

  assign leaf_o.call = (x_q > strike_q) ? x_q - strike_q : '0;
  assign leaf_o.put  = (strike_q > x_q) ? strike_q - x_q : '0;
  assign sat_o       = sat_q;

endmodule

@@ design/bop_rollback.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bop_rollback: three-stage node update unit
// Computes ((q*vu + (1-q)*vd) * disc) for the call and put lanes, each
// product rounded half up. The weighted average is formed as
// vd + q*(vu - vd), so the weighting and discount stages each need one multiplier per lane.
// ----------------------------------------------------------------------------
module bop_rollback (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bop_pkg::rb_req_t          req_i,
  input  logic [bop_pkg::ProbW-1:0] q_i,
  input  logic [bop_pkg::ProbW-1:0] disc_i,
  output logic                      out_valid_o,
  output bop_pkg::pair_t            out_o,
  output logic                      busy_o
);

  localparam int DiffW = bop_pkg::PriceW + 1;
  localparam int WgtW  = DiffW + bop_pkg::ProbW + 1;
  localparam int DscW  = bop_pkg::PriceW + bop_pkg::ProbW + 1;
  localparam logic signed [WgtW-1:0] HalfWgt = WgtW'(64'd1 << (bop_pkg::FracW - 1));
  localparam logic [DscW-1:0] HalfDsc = DscW'(64'd1 << (bop_pkg::FracW - 1));

  function automatic logic signed [WgtW-1:0] weigh(
    input logic [bop_pkg::PriceW-1:0] vu,
    input logic [bop_pkg::PriceW-1:0] vd,
    input logic [bop_pkg::ProbW-1:0]  q
  );
    logic signed [DiffW-1:0] diff;
    diff  = $signed({1'b0, vu}) - $signed({1'b0, vd});
    weigh = WgtW'(diff) * $signed(WgtW'(q));
  endfunction

  function automatic logic [bop_pkg::PriceW-1:0] average(
    input logic [bop_pkg::PriceW-1:0] vd,
    input logic signed [WgtW-1:0]     wgt
  );
    logic signed [WgtW-1:0] sum;
    sum     = $signed(WgtW'({vd, {bop_pkg::FracW{1'b0}}})) + wgt + HalfWgt;
    average = sum[bop_pkg::FracW +: bop_pkg::PriceW];
  endfunction

  function automatic logic [bop_pkg::PriceW-1:0] discount(
    input logic [bop_pkg::PriceW-1:0] avg,
    input logic [bop_pkg::ProbW-1:0]  disc
  );
    logic [DscW-1:0] full;
    full     = DscW'(avg) * DscW'(disc) + HalfDsc;
    discount = full[bop_pkg::FracW +: bop_pkg::PriceW];
  endfunction

  logic                       v1_q, v2_q, v3_q;
  logic signed [WgtW-1:0]     wc1_q, wp1_q;
  bop_pkg::pair_t             vd1_q;
  bop_pkg::pair_t             avg2_q;
  bop_pkg::pair_t             res3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wc1_q       <= weigh(req_i.vu.call, req_i.vd.call, q_i);
    wp1_q       <= weigh(req_i.vu.put, req_i.vd.put, q_i);
    vd1_q       <= req_i.vd;
    avg2_q.call <= average(vd1_q.call, wc1_q);
    avg2_q.put  <= average(vd1_q.put, wp1_q);
    res3_q.call <= discount(avg2_q.call, disc_i);
    res3_q.put  <= discount(avg2_q.put, disc_i);
  end

  assign out_valid_o = v3_q;
  assign out_o       = res3_q;
  assign busy_o      = v1_q | v2_q | v3_q;

endmodule

@@ design/binomial_option_pricer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_option_pricer: European call/put pricer on a binomial lattice
// Prices one request item at a time by leaf generation and backward
// induction over a recombining lattice held in a shift-line queue.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake          Payload
//   req_i     in    valid/ready        spot_price, strike_price (Q16.16)
//   rsp_o     out   valid/ready        call_price, put_price, saturated
//   APB       in    psel/penable/...   step_count, up_factor, down_factor,
//                                      up_probability, step_discount
//
// With n effective steps an item runs leaf generation (one shared price
// multiplier, one move per cycle) and then backward induction (one node
// per cycle through the three-stage rollback unit while the queue holds
// values to pop).
// A new request is taken only when the previous one has left the lattice;
// a finished result waits in the output register while the next one runs.
// Reset clears control state and loads the register defaults; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module binomial_option_pricer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bop_req_if.sink                     req_i,
  bop_rsp_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bop_pkg::AddrW-1:0]   paddr,
  input  logic [bop_pkg::DataW-1:0]   pwdata,
  output logic [bop_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SLeaf = 2'd1;
  localparam logic [1:0] SRoll = 2'd2;

  localparam int CmpW = (bop_pkg::NW > bop_pkg::StepW) ? bop_pkg::NW : bop_pkg::StepW;

  // Configuration registers.
  logic [bop_pkg::StepW-1:0]  step_count_q;
  logic [bop_pkg::FactW-1:0]  up_factor_q;
  logic [bop_pkg::FactW-1:0]  down_factor_q;
  logic [bop_pkg::ProbW-1:0]  up_prob_q;
  logic [bop_pkg::ProbW-1:0]  discount_q;
  logic                       cfg_wr;
  logic [bop_pkg::RegIdxW-1:0] reg_idx;

  // Control.
  logic [1:0]                 state_q, state_d;
  logic [bop_pkg::OccW-1:0]   occ_q, occ_d;
  logic [bop_pkg::NW-1:0]     t_q, t_d;
  logic [bop_pkg::NW-1:0]     j_q, j_d;
  bop_pkg::pair_t             held_q, held_d;

  logic                       req_fire;
  logic [bop_pkg::NW-1:0]     n_eff;
  logic [bop_pkg::ProbW-1:0]  q_eff;
  logic [bop_pkg::ProbW-1:0]  disc_eff;

  logic                       leaf_valid;
  logic                       leaf_last;
  bop_pkg::pair_t             leaf_val;
  logic                       leaf_sat;

  bop_pkg::rb_req_t           rb_req;
  logic                       rb_out_valid;
  bop_pkg::pair_t             rb_out;
  logic                       rb_busy;

  bop_pkg::chain_ctl_t        chain_ctl;
  bop_pkg::pair_t             push_val;
  bop_pkg::pair_t             head;
  logic [bop_pkg::OccW-1:0]   occ_after_pop;
  logic                       root_ready;
  logic                       slot_free;

  // Result register.
  logic                       rsp_valid_q, rsp_valid_d;
  logic [bop_pkg::PriceW-1:0] call_q, put_q;
  logic                       sat_q;
  logic                       rsp_load;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[bop_pkg::AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q  <= bop_pkg::StepW'(16);
      up_factor_q   <= bop_pkg::FactW'(64'd1 << bop_pkg::FracW);
      down_factor_q <= bop_pkg::FactW'(64'd1 << bop_pkg::FracW);
      up_prob_q     <= bop_pkg::ProbW'(64'd1 << (bop_pkg::FracW - 1));
      discount_q    <= bop_pkg::OneQ30;
    end else if (cfg_wr) begin
      case (reg_idx)
        bop_pkg::RegStepCount:  step_count_q  <= pwdata[bop_pkg::StepW-1:0];
        bop_pkg::RegUpFactor:   up_factor_q   <= pwdata[bop_pkg::FactW-1:0];
        bop_pkg::RegDownFactor: down_factor_q <= pwdata[bop_pkg::FactW-1:0];
        bop_pkg::RegUpProb:     up_prob_q     <= pwdata[bop_pkg::ProbW-1:0];
        bop_pkg::RegDiscount:   discount_q    <= pwdata[bop_pkg::ProbW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bop_pkg::RegStepCount:  prdata = bop_pkg::DataW'(step_count_q);
      bop_pkg::RegUpFactor:   prdata = bop_pkg::DataW'(up_factor_q);
      bop_pkg::RegDownFactor: prdata = bop_pkg::DataW'(down_factor_q);
      bop_pkg::RegUpProb:     prdata = bop_pkg::DataW'(up_prob_q);
      bop_pkg::RegDiscount:   prdata = bop_pkg::DataW'(discount_q);
      default:                prdata = '0;
    endcase
  end

  assign n_eff = (CmpW'(step_count_q) > CmpW'(bop_pkg::MaxSteps)) ?
                 bop_pkg::NW'(bop_pkg::MaxSteps) : bop_pkg::NW'(step_count_q);
  assign q_eff    = (up_prob_q > bop_pkg::OneQ30) ? bop_pkg::OneQ30 : up_prob_q;
  assign disc_eff = (discount_q > bop_pkg::OneQ30) ? bop_pkg::OneQ30 : discount_q;

  // ---------------------------------------------------------------------------
  // Leaf generation
  // ---------------------------------------------------------------------------
  assign req_i.ready = (state_q == SIdle);
  assign req_fire    = req_i.valid && req_i.ready;

  bop_leaf u_leaf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (req_fire),
    .spot_i       (req_i.spot_price),
    .strike_i     (req_i.strike_price),
    .steps_i      (n_eff),
    .up_i         (up_factor_q),
    .down_i       (down_factor_q),
    .leaf_valid_o (leaf_valid),
    .leaf_last_o  (leaf_last),
    .leaf_o       (leaf_val),
    .sat_o        (leaf_sat)
  );

  // ---------------------------------------------------------------------------
  // Backward induction. Leaves enter the queue from the all-up leaf down, so
  // each pass pops the up child first and pairs it with the next value.
  // Results of a pass re-enter behind the values still waiting.
  // ---------------------------------------------------------------------------
  assign chain_ctl.pop  = (state_q == SRoll) && (t_q != '0) && (occ_q != '0);
  assign chain_ctl.push = leaf_valid || rb_out_valid;
  assign occ_after_pop  = occ_q - bop_pkg::OccW'(chain_ctl.pop);
  assign chain_ctl.push_idx = occ_after_pop[bop_pkg::IdxW-1:0];
  assign push_val       = leaf_valid ? leaf_val : rb_out;

  bop_chain u_chain (
    .clk_i      (clk_i),
    .ctl_i      (chain_ctl),
    .push_val_i (push_val),
    .head_o     (head)
  );

  assign rb_req.valid = chain_ctl.pop && (j_q != '0);
  assign rb_req.vu    = held_q;
  assign rb_req.vd    = head;

  bop_rollback u_rollback (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (rb_req),
    .q_i         (q_eff),
    .disc_i      (disc_eff),
    .out_valid_o (rb_out_valid),
    .out_o       (rb_out),
    .busy_o      (rb_busy)
  );

  // The root is alone in the queue once every pass has issued its pops and the last result has re-entered.
  assign root_ready = (state_q == SRoll) && (t_q == '0) && (occ_q == bop_pkg::OccW'(1));
  assign slot_free  = !rsp_valid_q || rsp_o.ready;
  assign rsp_load   = root_ready && slot_free;

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q + bop_pkg::OccW'(chain_ctl.push) - bop_pkg::OccW'(chain_ctl.pop);
    t_d     = t_q;
    j_d     = j_q;
    held_d  = held_q;
    case (state_q)
      SIdle: begin
        if (req_fire) begin
          state_d = SLeaf;
          occ_d   = '0;
          t_d     = n_eff;
          j_d     = '0;
        end
      end
      SLeaf: begin
        if (leaf_last) begin
          state_d = SRoll;
        end
      end
      SRoll: begin
        if (chain_ctl.pop) begin
          held_d = head;
          if (j_q == t_q) begin
            j_d = '0;
            t_d = t_q - bop_pkg::NW'(1);
          end else begin
            j_d = j_q + bop_pkg::NW'(1);
          end
        end
        if (rsp_load) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      occ_q   <= '0;
      t_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      t_q     <= t_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      call_q <= head.call;
      put_q  <= head.put;
      sat_q  <= leaf_sat;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.call_price = call_q;
  assign rsp_o.put_price  = put_q;
  assign rsp_o.saturated  = sat_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_rb_only_in_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rb_out_valid |-> state_q == SRoll)
    else $error("rollback result outside backward induction");

  a_root_unit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_ready |-> !rb_busy)
    else $error("root taken while node updates are still in flight");

  a_leaf_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    leaf_valid |-> (state_q == SLeaf) && (occ_q < bop_pkg::OccW'(bop_pkg::LatDepth)))
    else $error("leaf pushed into a full value chain");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == SLeaf) && (occ_q == '0))
    else $error("request accepted without an empty value chain");

endmodule
